// ===== src/dcfp_pkg.sv =====
// shared types, character codes and the field decoder of the drive command frame parser
package dcfp_pkg;

    localparam int FRAME_LEN   = 16;
    localparam int POS_W       = $clog2(FRAME_LEN);
    localparam int QUEUE_DEPTH = 2;

    // byte positions inside a frame
    localparam int POS_START = 0;
    localparam int POS_SPEED = 1;
    localparam int POS_TURN  = 6;
    localparam int POS_TURN_MARK = 5;
    localparam int FIELD_LEN = 4;

    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_V     = 8'h76;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic signed [15:0] DIGIT_BASE = 16'sd48;
    localparam logic signed [15:0] WEIGHT_HUNDREDS = 16'sd100;
    localparam logic signed [15:0] WEIGHT_TENS = 16'sd10;
    localparam logic signed [15:0] RANGE_MAX = 16'sd100;
    localparam logic signed [15:0] RANGE_MIN = -16'sd100;

    // sign byte in [0], digit bytes in [1] to [3]
    typedef logic [FIELD_LEN-1:0][7:0] t_field;

    typedef struct packed {
        logic   marks_ok;
        t_field speed_field;
        t_field turn_field;
    } t_frame;

    typedef struct packed {
        logic   push;
        t_frame frame;
    } t_front_out;

    function automatic logic signed [7:0] decode_value(input t_field f);
        logic               neg;
        logic               d2_minus;
        logic               d2_space;
        logic               d3_minus;
        logic               d3_space;
        logic signed [15:0] a;
        logic signed [15:0] b;
        logic signed [15:0] c;
        logic signed [15:0] v;
        begin
            neg      = (f[0] == CH_MINUS);
            d2_minus = (f[1] == CH_MINUS);
            d2_space = (f[1] == CH_SPACE);
            d3_minus = (f[2] == CH_MINUS);
            d3_space = (f[2] == CH_SPACE);
            a = $signed({8'd0, f[1]}) - DIGIT_BASE;
            b = $signed({8'd0, f[2]}) - DIGIT_BASE;
            c = $signed({8'd0, f[3]}) - DIGIT_BASE;
            v = 16'sd0;
            // hundreds count only with no blank or minus in the later digits
            if (!d2_minus && !d2_space && !d3_minus && !d3_space) begin
                if (neg) begin
                    v = v - a * WEIGHT_HUNDREDS;
                end else begin
                    v = v + a * WEIGHT_HUNDREDS;
                end
            end
            if (!d3_minus && !d3_space) begin
                if (neg || d2_minus) begin
                    v = v - b * WEIGHT_TENS;
                end else begin
                    v = v + b * WEIGHT_TENS;
                end
            end
            if (neg || d2_minus || d3_minus) begin
                v = v - c;
            end else begin
                v = v + c;
            end
            if (v < RANGE_MIN || v > RANGE_MAX) begin
                v = 16'sd0;
            end
            return v[7:0];
        end
    endfunction

endpackage

// ===== src/dcfp_front.sv =====
// byte assembler: gathers received bytes into frames and checks the markers
module dcfp_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_data,
    input  logic                   i_push,
    input  logic                   i_full,
    input  logic [7:0]             i_rx_byte,
    output dcfp_pkg::t_front_out   o_front
);

    logic [dcfp_pkg::POS_W-1:0] r_pos;
    logic [dcfp_pkg::POS_W-1:0] n_pos;
    logic                       r_enable;
    logic [7:0]                 r_frame [dcfp_pkg::FRAME_LEN];
    logic                       take;
    logic                       last;

    assign take = i_push && !i_full && r_enable;
    assign last = (r_pos == dcfp_pkg::POS_W'(dcfp_pkg::FRAME_LEN - 1));

    always_comb begin
        n_pos = r_pos;
        if (take) begin
            n_pos = last ? '0 : r_pos + dcfp_pkg::POS_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_enable <= 1'b0;
        end else begin
            r_pos <= n_pos;
            if (i_cfg_valid) begin
                r_enable <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_frame[r_pos] <= i_rx_byte;
        end
    end

    always_comb begin
        o_front.push = take && last;
        o_front.frame.marks_ok = (r_frame[dcfp_pkg::POS_START] == dcfp_pkg::CH_S)
                              && (r_frame[dcfp_pkg::POS_TURN_MARK] == dcfp_pkg::CH_T)
                              && (i_rx_byte == dcfp_pkg::CH_V);
        for (int k = 0; k < dcfp_pkg::FIELD_LEN; k++) begin
            o_front.frame.speed_field[k] = r_frame[dcfp_pkg::POS_SPEED + k];
            o_front.frame.turn_field[k]  = r_frame[dcfp_pkg::POS_TURN + k];
        end
    end

endmodule

// ===== src/dcfp_fifo.sv =====
// short frame queue between the byte assembler and the decoder
module dcfp_fifo #(
    parameter int DEPTH = dcfp_pkg::QUEUE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  dcfp_pkg::t_front_out i_front,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output dcfp_pkg::t_frame     o_head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dcfp_pkg::t_frame r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_front.push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_front.frame;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("frame queue count above depth");
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("frame queue count missed a push");
`endif

endmodule

// ===== src/dcfp_back.sv =====
// field decoder with held commands and the result register
module dcfp_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  dcfp_pkg::t_frame        i_head,
    output logic                    o_q_pop,
    input  logic                    i_pop,
    output logic                    o_empty,
    output logic                    o_frame_valid,
    output logic signed [7:0]       o_speed_cmd,
    output logic signed [7:0]       o_turn_cmd
);

    logic               r_out_valid;
    logic               r_out_frame_valid;
    logic signed [7:0]  r_out_speed;
    logic signed [7:0]  r_out_turn;
    logic signed [7:0]  r_held_speed;
    logic signed [7:0]  r_held_turn;
    logic signed [7:0]  n_held_speed;
    logic signed [7:0]  n_held_turn;
    logic signed [7:0]  dec_speed;
    logic signed [7:0]  dec_turn;

    assign o_q_pop   = !i_q_empty && (!r_out_valid || i_pop);
    assign dec_speed = dcfp_pkg::decode_value(i_head.speed_field);
    assign dec_turn  = dcfp_pkg::decode_value(i_head.turn_field);

    always_comb begin
        n_held_speed = r_held_speed;
        n_held_turn  = r_held_turn;
        if (o_q_pop && i_head.marks_ok) begin
            n_held_speed = dec_speed;
            n_held_turn  = dec_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_held_speed <= '0;
            r_held_turn  <= '0;
        end else begin
            r_held_speed <= n_held_speed;
            r_held_turn  <= n_held_turn;
            if (o_q_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_out_frame_valid <= i_head.marks_ok;
            r_out_speed       <= n_held_speed;
            r_out_turn        <= n_held_turn;
        end
    end

    assign o_empty       = !r_out_valid;
    assign o_frame_valid = r_out_frame_valid;
    assign o_speed_cmd   = r_out_speed;
    assign o_turn_cmd    = r_out_turn;

`ifndef NO_ASSERTIONS
    a_bad_frame_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && !i_head.marks_ok) |=> ($stable(r_held_speed) && $stable(r_held_turn)))
        else $error("bad frame changed held commands");
    a_result_from_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_q_pop))
        else $error("result appeared without a queue transfer");
`endif

endmodule

// ===== src/drive_command_frame_parser_core.sv =====
// top level of the drive command frame parser
// Usage:
//   Input queue side: raise push with a byte on i_rx_byte; a transfer happens at
//   a clock edge with push high and full low. Bytes that arrive while enable is
//   low are taken and dropped. Every sixteenth enabled byte closes a frame.
//   Result queue side: while empty is low, o_frame_valid, o_speed_cmd and
//   o_turn_cmd show the oldest result; pop high with empty low takes it.
//   Configuration: i_cfg_data is written into enable at an edge with i_cfg_valid
//   high; o_cfg_ready is always high. Write it only while the block is idle.
// Timing:
//   one byte per cycle sustained while full is low. A result shows after the edge
//   that takes the last byte of its frame: that edge writes the frame into the
//   frame queue, where it waits at the head until the result register is free,
//   and it is decoded into the result register at the edge that pops it.
// Reset and stalls:
//   synchronous reset clears the byte count, enable, held commands and both
//   queues. If pop stays low, up to QUEUE_DEPTH frames wait behind the result
//   register; once the frame queue holds QUEUE_DEPTH frames, full rises and
//   every byte waits until the decoder frees a slot.
module drive_command_frame_parser_core #(
    parameter int QUEUE_DEPTH = dcfp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_data,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        i_rx_byte,
    output logic              empty,
    input  logic              pop,
    output logic              o_frame_valid,
    output logic signed [7:0] o_speed_cmd,
    output logic signed [7:0] o_turn_cmd
);

    dcfp_pkg::t_front_out front;
    dcfp_pkg::t_frame     head;
    logic                 q_empty;
    logic                 q_pop;

    assign o_cfg_ready = 1'b1;

    dcfp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .i_full      (full),
        .i_rx_byte   (i_rx_byte),
        .o_front     (front)
    );

    dcfp_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_front (front),
        .i_pop   (q_pop),
        .o_full  (full),
        .o_empty (q_empty),
        .o_head  (head)
    );

    dcfp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_head        (head),
        .o_q_pop       (q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_frame_valid (o_frame_valid),
        .o_speed_cmd   (o_speed_cmd),
        .o_turn_cmd    (o_turn_cmd)
    );

endmodule

// ===== tb/tb_drive_command_frame_parser_core.sv =====
// testbench for the drive command frame parser core: frame table, random frames, queue handshakes
module tb_drive_command_frame_parser_core;
    import dcfp_pkg::*;

    localparam int NUM_ROWS      = 15;
    localparam int PHASE_BYTES   = 96;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 200;
    localparam int QUIET_LIMIT   = 2000;
    localparam logic [7:0] DIGIT_ZERO = DIGIT_BASE[7:0];

    typedef struct packed {
        logic              valid;
        logic signed [7:0] speed;
        logic signed [7:0] turn;
    } drive_cmd_t;

    typedef struct packed {
        logic [127:0] text;
        logic         enabled;
        logic         typed;
        drive_cmd_t   cmd;
    } frame_row_t;

    typedef enum int {FRAME_GOOD, FRAME_BROKEN, FRAME_NOISE} frame_kind_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        i_rx_byte = 8'h00;
    logic              empty;
    logic              pop = 1'b0;
    logic              o_frame_valid;
    logic signed [7:0] o_speed_cmd;
    logic signed [7:0] o_turn_cmd;

    drive_command_frame_parser_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .push          (push),
        .full          (full),
        .i_rx_byte     (i_rx_byte),
        .empty         (empty),
        .pop           (pop),
        .o_frame_valid (o_frame_valid),
        .o_speed_cmd   (o_speed_cmd),
        .o_turn_cmd    (o_turn_cmd)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    int         error_count = 0;
    int         outstanding = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;
    logic       hold_req = 1'b0;
    logic       hold_req_d = 1'b0;
    int         hold_left = 0;
    int         quiet_cycles = 0;
    logic       drv_enable = 1'b0;

    logic [7:0]        frame_store [FRAME_LEN];
    int                frame_pos;
    logic              model_enable;
    logic signed [7:0] held_speed_cmd;
    logic signed [7:0] held_turn_cmd;
    drive_cmd_t        cmd_expect_q [$];
    frame_row_t        typed_q [$];
    frame_row_t        frame_rows [NUM_ROWS];

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    // sign byte, then the three digit bytes
    function automatic logic signed [7:0] field_cmd(input logic [7:0] sgn, input logic [7:0] d2,
                                                    input logic [7:0] d3, input logic [7:0] d4);
        int w_h;
        int w_t;
        int w_u;
        int sum;
        if (sgn == CH_MINUS) begin
            w_h = -100; w_t = -10; w_u = -1;
        end else begin
            w_h = 100; w_t = 10; w_u = 1;
        end
        if (d2 == CH_MINUS) begin
            w_h = 0; w_t = -10; w_u = -1;
        end else if (d2 == CH_SPACE) begin
            w_h = 0;
        end
        if (d3 == CH_MINUS) begin
            w_h = 0; w_t = 0; w_u = -1;
        end else if (d3 == CH_SPACE) begin
            w_h = 0; w_t = 0;
        end
        sum = w_h * (int'(d2) - int'(DIGIT_ZERO)) + w_t * (int'(d3) - int'(DIGIT_ZERO))
            + w_u * (int'(d4) - int'(DIGIT_ZERO));
        if (sum < int'(RANGE_MIN) || sum > int'(RANGE_MAX))
            sum = 0;
        return sum[7:0];
    endfunction

    always @(posedge i_clk) begin
        drive_cmd_t want;
        drive_cmd_t cmd;
        frame_row_t row;
        logic       marks_ok;
        if (!i_rst_n) begin
            frame_pos = 0;
            model_enable = 1'b0;
            held_speed_cmd = 8'sd0;
            held_turn_cmd = 8'sd0;
            cmd_expect_q.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                model_enable = i_cfg_data;
            if (push && !full && model_enable) begin
                frame_store[frame_pos] = i_rx_byte;
                if (frame_pos == FRAME_LEN - 1) begin
                    frame_pos = 0;
                    marks_ok = frame_store[POS_START] == CH_S
                            && frame_store[POS_TURN_MARK] == CH_T
                            && frame_store[FRAME_LEN-1] == CH_V;
                    if (marks_ok) begin
                        held_speed_cmd = field_cmd(frame_store[POS_SPEED], frame_store[POS_SPEED+1],
                                                   frame_store[POS_SPEED+2], frame_store[POS_SPEED+3]);
                        held_turn_cmd = field_cmd(frame_store[POS_TURN], frame_store[POS_TURN+1],
                                                  frame_store[POS_TURN+2], frame_store[POS_TURN+3]);
                    end
                    cmd = {marks_ok, held_speed_cmd, held_turn_cmd};
                    if (typed_q.size() != 0) begin
                        row = typed_q.pop_front();
                        if (row.typed)
                            cmd = row.cmd;
                    end
                    cmd_expect_q.push_back(cmd);
                end else begin
                    frame_pos++;
                end
            end
            if (pop && !empty) begin
                if (cmd_expect_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected result valid=%0b speed=%0d turn=%0d",
                                            o_frame_valid, o_speed_cmd, o_turn_cmd));
                end else begin
                    want = cmd_expect_q.pop_front();
                    if (o_frame_valid !== want.valid)
                        flag_mismatch($sformatf("frame_valid %0b, expected %0b",
                                                o_frame_valid, want.valid));
                    if (o_speed_cmd !== want.speed)
                        flag_mismatch($sformatf("speed_cmd %0d, expected %0d",
                                                o_speed_cmd, want.speed));
                    if (o_turn_cmd !== want.turn)
                        flag_mismatch($sformatf("turn_cmd %0d, expected %0d",
                                                o_turn_cmd, want.turn));
                end
            end
        end
        outstanding <= cmd_expect_q.size();
    end

    always @(posedge i_clk) begin
        hold_req_d <= hold_req;
        if (!i_rst_n) begin
            pop <= 1'b0;
            hold_left <= 0;
        end else if (hold_req && !hold_req_d) begin
            pop <= 1'b0;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            pop <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        drv_enable = value;
    endtask

    // split_at below FRAME_LEN drops enable for a few bytes before that byte
    task automatic send_frame(input logic [127:0] text, input int split_at);
        int k;
        int n;
        for (k = 0; k < FRAME_LEN; k++) begin
            if (k == split_at) begin
                wait_idle();
                write_enable(1'b0);
                n = $urandom_range(1, 6);
                repeat (n) send_byte(8'($urandom_range(255)));
                wait_idle();
                write_enable(1'b1);
            end
            send_byte(text[127-8*k -: 8]);
        end
    endtask

    function automatic logic [7:0] pick_field_byte();
        case ($urandom_range(7))
            0, 1: return DIGIT_ZERO;
            2, 3, 4: return DIGIT_ZERO + 8'($urandom_range(9));
            5: return CH_MINUS;
            6: return CH_SPACE;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [127:0] make_frame(input frame_kind_t kind);
        logic [127:0] text;
        int           k;
        int           mark_pos;
        for (k = 0; k < FRAME_LEN; k++)
            text[127-8*k -: 8] = 8'($urandom_range(255));
        if (kind != FRAME_NOISE) begin
            text[127-8*POS_START -: 8] = CH_S;
            text[127-8*POS_TURN_MARK -: 8] = CH_T;
            text[127-8*(FRAME_LEN-1) -: 8] = CH_V;
            for (k = 0; k < FIELD_LEN; k++) begin
                text[127-8*(POS_SPEED+k) -: 8] = pick_field_byte();
                text[127-8*(POS_TURN+k) -: 8] = pick_field_byte();
            end
        end
        if (kind == FRAME_BROKEN) begin
            case ($urandom_range(2))
                0: mark_pos = POS_START;
                1: mark_pos = POS_TURN_MARK;
                default: mark_pos = FRAME_LEN - 1;
            endcase
            text[127-8*mark_pos -: 8] = text[127-8*mark_pos -: 8] ^ 8'($urandom_range(1, 255));
        end
        return text;
    endfunction

    initial begin
        int          r;
        int          phase;
        int          phase_bytes;
        int          split_at;
        frame_kind_t kind;
        frame_row_t  row;

        frame_rows[0]  = {"xxxxxxxxxxxxxxxx", 1'b1, 1'b1, 1'b0, 8'sd0, 8'sd0};
        frame_rows[1]  = {"s+100t+100.....v", 1'b1, 1'b1, 1'b1, 8'sd100, 8'sd100};
        frame_rows[2]  = {"s-100t-100.....v", 1'b1, 1'b1, 1'b1, -8'sd100, -8'sd100};
        frame_rows[3]  = {"s+042t-007.....v", 1'b1, 1'b1, 1'b1, 8'sd42, -8'sd7};
        frame_rows[4]  = {"S+011t+011.....v", 1'b1, 1'b1, 1'b0, 8'sd42, -8'sd7};
        frame_rows[5]  = {"s+011T+011.....v", 1'b1, 1'b1, 1'b0, 8'sd42, -8'sd7};
        frame_rows[6]  = {"s+011t+011.....V", 1'b1, 1'b1, 1'b0, 8'sd42, -8'sd7};
        frame_rows[7]  = {"s+101t-101.....v", 1'b1, 1'b1, 1'b1, 8'sd0, 8'sd0};
        frame_rows[8]  = {"s  42t  -5.....v", 1'b1, 1'b0, 17'd0};
        frame_rows[9]  = {"s -42t - 7.....v", 1'b1, 1'b0, 17'd0};
        frame_rows[10] = {"s--42t-- 7.....v", 1'b1, 1'b0, 17'd0};
        frame_rows[11] = {"s+050t+050.....v", 1'b0, 1'b0, 17'd0};
        frame_rows[12] = {"s", 8'h00, 8'hff, 8'h00, "9", "t", 8'hff, "099", ".....", "v",
                          1'b1, 1'b0, 17'd0};
        frame_rows[13] = {"s 0:0t+0;9.....v", 1'b1, 1'b0, 17'd0};
        frame_rows[14] = {"s-0:0t+000.....v", 1'b1, 1'b0, 17'd0};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < NUM_ROWS; r++) begin
            row = frame_rows[r];
            if (row.enabled != drv_enable) begin
                wait_idle();
                write_enable(row.enabled);
            end
            if (row.enabled)
                typed_q.push_back(row);
            send_frame(row.text, FRAME_LEN);
        end

        // receiver holds off while frames keep coming, so the input side stalls
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_req <= 1'b1;
        repeat (6) send_frame(make_frame(FRAME_GOOD), FRAME_LEN);
        hold_req <= 1'b0;

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct = 51;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct <= 51;
                end
                default: begin
                    send_idle_pct = 18;
                    recv_stall_pct <= 18;
                end
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                r = $urandom_range(99);
                kind = (r < 75) ? FRAME_GOOD : (r < 90) ? FRAME_BROKEN : FRAME_NOISE;
                split_at = ($urandom_range(9) == 0) ? $urandom_range(FRAME_LEN - 1) : FRAME_LEN;
                send_frame(make_frame(kind), split_at);
                phase_bytes += FRAME_LEN;
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
